// ----- rtl/mmc_pkg.sv -----
// shared types, constants and the firmware type classifier for the memory map coalescer
// no dependencies

package mmc_pkg;

    localparam int MAX_REGIONS_DEF = 64;
    localparam int PAGE_SHIFT      = 12;

    localparam int FTYPE_W  = 32;
    localparam int ADDR_W   = 64;
    localparam int PAGES_W  = 52;
    localparam int INDEX_W  = 6;
    localparam int TOTAL_W  = 7;

    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 144;

    typedef enum logic [1:0] {
        ACT_NEW   = 2'd0,
        ACT_MERGE = 2'd1,
        ACT_DROP  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        CLS_AVAILABLE = 3'd0,
        CLS_ACPI      = 3'd1,
        CLS_NVS       = 3'd2,
        CLS_BAD       = 3'd3,
        CLS_RESERVED  = 3'd4
    } cls_t;

    localparam logic [FTYPE_W-1:0] FT_LOADER_CODE  = 32'd1;
    localparam logic [FTYPE_W-1:0] FT_LOADER_DATA  = 32'd2;
    localparam logic [FTYPE_W-1:0] FT_BOOT_CODE    = 32'd3;
    localparam logic [FTYPE_W-1:0] FT_BOOT_DATA    = 32'd4;
    localparam logic [FTYPE_W-1:0] FT_CONVENTIONAL = 32'd7;
    localparam logic [FTYPE_W-1:0] FT_UNUSABLE     = 32'd8;
    localparam logic [FTYPE_W-1:0] FT_ACPI_RECLAIM = 32'd9;
    localparam logic [FTYPE_W-1:0] FT_ACPI_NVS     = 32'd10;

    // held region, apart from the region count
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        cls_t              cls;
        logic              stopped;
    } region_state_t;

    typedef struct packed {
        action_t            action;
        logic [INDEX_W-1:0] index;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  length;
        cls_t               cls;
        logic [TOTAL_W-1:0] total;
    } region_result_t;

    function automatic cls_t classify(input logic [FTYPE_W-1:0] ftype);
        cls_t c;
        unique case (ftype)
            FT_LOADER_CODE, FT_LOADER_DATA, FT_BOOT_CODE,
            FT_BOOT_DATA, FT_CONVENTIONAL: c = CLS_AVAILABLE;
            FT_ACPI_RECLAIM:               c = CLS_ACPI;
            FT_ACPI_NVS:                   c = CLS_NVS;
            FT_UNUSABLE:                   c = CLS_BAD;
            default:                       c = CLS_RESERVED;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/mmc_merge.sv -----
// merge decision for one descriptor against the held region
// depends on mmc_pkg

module mmc_merge
    import mmc_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int CNT_W       = $clog2(MAX_REGIONS + 1)
) (
    input  logic                start_of_map,
    input  logic [FTYPE_W-1:0]  firmware_type,
    input  logic [ADDR_W-1:0]   phys_start,
    input  logic [PAGES_W-1:0]  page_count,
    input  region_state_t       cur_state,
    input  logic [CNT_W-1:0]    cur_count,
    output region_state_t       next_state,
    output logic [CNT_W-1:0]    next_count,
    output region_result_t      result
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

    cls_t                   cls;
    logic [ADDR_W-1:0]      len;
    logic [ADDR_W-1:0]      last_end;
    logic [CNT_W-1:0]       cnt_eff;
    logic                   stop_eff;
    logic                   adjoins;
    logic                   full;
    action_t                act;
    logic [CNT_W-1:0]       idx;
    logic [CNT_W+INDEX_W-1:0] idx_wide;
    logic [CNT_W+TOTAL_W-1:0] total_wide;

    assign cls      = classify(firmware_type);
    assign len      = {page_count, {PAGE_SHIFT{1'b0}}};
    assign last_end = cur_state.base + cur_state.length;
    assign cnt_eff  = start_of_map ? '0 : cur_count;
    assign stop_eff = start_of_map ? 1'b0 : cur_state.stopped;
    assign adjoins  = (cnt_eff != '0) && (last_end == phys_start);
    assign full     = cnt_eff >= MAX_CNT;

    always_comb begin
        next_state         = cur_state;
        next_state.stopped = stop_eff;
        next_count         = cnt_eff;
        act                = ACT_DROP;
        idx                = cnt_eff - CNT_W'(1);
        priority if (stop_eff) begin
            act = ACT_DROP;
        end else if (full) begin
            if (cls == CLS_AVAILABLE && cur_state.cls == CLS_AVAILABLE && adjoins) begin
                next_state.length = cur_state.length + len;
                act               = ACT_MERGE;
            end else begin
                next_state.stopped = 1'b1;
                act                = ACT_DROP;
            end
        end else if (adjoins && cur_state.cls == cls) begin
            next_state.length = cur_state.length + len;
            act               = ACT_MERGE;
        end else begin
            next_state.base   = phys_start;
            next_state.length = len;
            next_state.cls    = cls;
            next_count        = cnt_eff + CNT_W'(1);
            idx               = cnt_eff;
            act               = ACT_NEW;
        end
    end

    assign idx_wide   = {{INDEX_W{1'b0}}, idx};
    assign total_wide = {{TOTAL_W{1'b0}}, next_count};

    always_comb begin
        result.action = act;
        result.total  = total_wide[TOTAL_W-1:0];
        if (act == ACT_DROP) begin
            result.index  = '0;
            result.base   = '0;
            result.length = '0;
            result.cls    = CLS_AVAILABLE;
        end else begin
            result.index  = idx_wide[INDEX_W-1:0];
            result.base   = next_state.base;
            result.length = next_state.length;
            result.cls    = next_state.cls;
        end
    end

endmodule

// ----- rtl/memory_map_coalescer.sv -----
// Memory map coalescer. Takes one firmware memory descriptor per cycle unless held
// by output back-pressure, and reports one result item per descriptor: the descriptor
// sits in an input register, the merge against the single held region (two 64-bit
// adds and a compare) runs combinationally into the result register. Throughput is
// one item per clock with no gaps while m_tready is high, as the held region is
// written together with the result register. No clearing pass is needed after reset.
// depends on mmc_pkg and mmc_merge

module memory_map_coalescer
    import mmc_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // firmware_type, phys_start, page_count, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // start_of_map
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // region_index, region_base, region_length, region_class, region_total
    output logic [M_TDATA_W-1:0] m_tdata,
    // action
    output logic [1:0]           m_tuser
);

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    logic                 in_valid_reg;
    logic                 in_som_reg;
    logic [FTYPE_W-1:0]   in_ftype_reg;
    logic [ADDR_W-1:0]    in_start_reg;
    logic [PAGES_W-1:0]   in_pages_reg;

    region_state_t        state_reg;
    region_state_t        state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    region_result_t       result_next;
    region_result_t       result_reg;
    logic                 out_valid_reg;

    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    mmc_merge #(
        .MAX_REGIONS (MAX_REGIONS),
        .CNT_W       (CNT_W)
    ) u_merge (
        .start_of_map  (in_som_reg),
        .firmware_type (in_ftype_reg),
        .phys_start    (in_start_reg),
        .page_count    (in_pages_reg),
        .cur_state     (state_reg),
        .cur_count     (count_reg),
        .next_state    (state_next),
        .next_count    (count_next),
        .result        (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_som_reg   <= s_tuser;
            in_ftype_reg <= s_tdata[31:0];
            in_start_reg <= s_tdata[95:32];
            in_pages_reg <= s_tdata[147:96];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            count_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.action;
    assign m_tdata  = {result_reg.total, result_reg.cls, result_reg.length,
                       result_reg.base, result_reg.index};

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.action == ACT_DROP |-> m_tdata[136:0] == '0)
        else $error("dropped item carries region fields");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count beyond table size");

    a_stop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.stopped) |-> count_reg == CNT_W'(MAX_REGIONS))
        else $error("map stopped with table not full");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_valid_reg |-> m_tready)
        else $error("result overwritten before taken");

    a_merge_count: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result_next.action == ACT_MERGE |=> $stable(count_reg))
        else $error("merge changed region count");

endmodule
